@@ rtl/cals_pkg.sv @@
// Shared types and constants for the CAN alias login sequencer.
// Holds field widths, input mode codes, frame kinds, register indexes and generator constants.
// No dependencies; imported by cals_alias_gen and can_alias_login_sequencer.
`default_nettype none

package cals_pkg;

    // field widths
    localparam int unsigned NODE_ID_W = 48;
    localparam int unsigned HALF_W    = 24;
    localparam int unsigned ALIAS_W   = 12;
    localparam int unsigned COUNT_W   = 7;
    localparam int unsigned TICKS_W   = 8;
    localparam int unsigned EVENT_W   = 6;
    localparam int unsigned KIND_W    = 4;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned CFG_IDX_W = 3;

    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // input item modes
    localparam t_mode MODE_START    = 2'd0;
    localparam t_mode MODE_POLL     = 2'd1;
    localparam t_mode MODE_CONFLICT = 2'd2;

    // frame kinds
    localparam t_kind KIND_CID7        = 4'd0;
    localparam t_kind KIND_CID6        = 4'd1;
    localparam t_kind KIND_CID5        = 4'd2;
    localparam t_kind KIND_CID4        = 4'd3;
    localparam t_kind KIND_RID         = 4'd4;
    localparam t_kind KIND_AMD         = 4'd5;
    localparam t_kind KIND_INIT_FULL   = 4'd6;
    localparam t_kind KIND_INIT_SIMPLE = 4'd7;
    localparam t_kind KIND_PRODUCER    = 4'd8;
    localparam t_kind KIND_CONSUMER    = 4'd9;

    // configuration register indexes
    localparam t_cfg_idx REG_NODE_ID         = 3'd0;
    localparam t_cfg_idx REG_PRODUCER_COUNT  = 3'd1;
    localparam t_cfg_idx REG_CONSUMER_COUNT  = 3'd2;
    localparam t_cfg_idx REG_SIMPLE_PROTOCOL = 3'd3;
    localparam t_cfg_idx REG_WAIT_TICKS      = 3'd4;

    localparam logic [TICKS_W-1:0] WAIT_TICKS_RESET = 8'd3;

    // seed generator addends
    localparam logic [HALF_W-1:0] GEN_LO_ADD = 24'h1B0CA3;
    localparam logic [HALF_W-1:0] GEN_HI_ADD = 24'h7A4BA9;

    // result of the seed / alias unit
    typedef struct packed {
        logic [NODE_ID_W-1:0] seed;
        logic [ALIAS_W-1:0]   alias_val;
    } t_alias_res;

endpackage

`default_nettype wire

@@ rtl/cals_alias_gen.sv @@
// Seed generator and alias hash for the CAN alias login sequencer.
// Picks the node ID (start) or the advanced seed (conflict) and folds it into a 12-bit alias.
// Depends on cals_pkg.
`default_nettype none

module cals_alias_gen
    import cals_pkg::*;
(
    input  wire logic                 i_conflict,
    input  wire logic [NODE_ID_W-1:0] i_seed,
    input  wire logic [NODE_ID_W-1:0] i_node_id,
    output t_alias_res                o_res
);

    logic [HALF_W-1:0] w_lo;
    logic [HALF_W-1:0] w_hi;
    logic [HALF_W-1:0] w_t1;
    logic [HALF_W-1:0] w_t2;
    logic [HALF_W+1:0] w_lo_sum;
    logic [HALF_W+1:0] w_hi_sum;
    logic [HALF_W-1:0] w_lo_new;
    logic [NODE_ID_W-1:0] w_adv;
    logic [NODE_ID_W-1:0] w_seed;

    // advance the seed: shifted halves plus constants, upper carry folded into the low half
    assign w_lo     = i_seed[HALF_W-1:0];
    assign w_hi     = i_seed[NODE_ID_W-1:HALF_W];
    assign w_t1     = {w_lo[14:0], w_hi[23:15]};
    assign w_t2     = {w_hi[14:0], 9'd0};
    assign w_lo_sum = {2'b00, w_lo} + {2'b00, w_t1} + {2'b00, GEN_LO_ADD};
    assign w_hi_sum = {2'b00, w_hi} + {2'b00, w_t2} + {2'b00, GEN_HI_ADD};
    assign w_lo_new = w_lo_sum[HALF_W-1:0] + {22'd0, w_hi_sum[HALF_W+1:HALF_W]};
    // halves trade places in the new seed
    assign w_adv    = {w_lo_new, w_hi_sum[HALF_W-1:0]};

    assign w_seed = i_conflict ? w_adv : i_node_id;

    // alias hash: xor of the four 12-bit quarters
    assign o_res.seed      = w_seed;
    assign o_res.alias_val = w_seed[11:0] ^ w_seed[23:12] ^ w_seed[35:24] ^ w_seed[47:36];

endmodule

`default_nettype wire

@@ rtl/can_alias_login_sequencer.sv @@
// CAN alias login sequencer: one result transaction per input transaction.
// An accepted item goes into the input register, then its result into the result register.
// Throughput: one item per cycle while not stalled by m_axis_tready; one pass of step logic.
// Reset (i_rst_n low, synchronous): idle step, zero seed, alias, cursor and flags,
// config registers at their defaults (wait_ticks 3), both buffers empty.
// Depends on cals_pkg and cals_alias_gen.
`default_nettype none

module can_alias_login_sequencer
    import cals_pkg::*;
#(
    parameter int unsigned MAX_EVENTS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [NODE_ID_W-1:0] i_cfg_data,
    // input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [15:0]          s_axis_tdata,  // tx_accept[0], timer_ticks[8:1], zero[15:9]
    input  wire logic [MODE_W-1:0]    s_axis_tuser,  // mode[1:0]
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [39:0]               m_axis_tdata,  // frame_valid[0], id_slice[12:1],
                                                     // alias_out[24:13], event_number[30:25],
                                                     // is_permitted[31], is_initialized[32],
                                                     // login_done[33], zero[39:34]
    output logic [KIND_W-1:0]         m_axis_tuser   // frame_kind[3:0]
);

    localparam int unsigned CW = $clog2(MAX_EVENTS + 1);
    localparam int unsigned SW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam logic [SW-1:0] MAX_EXT = SW'(MAX_EVENTS);

    // login step codes
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CID7 = 4'd1;
    localparam logic [3:0] ST_CID6 = 4'd2;
    localparam logic [3:0] ST_CID5 = 4'd3;
    localparam logic [3:0] ST_CID4 = 4'd4;
    localparam logic [3:0] ST_WAIT = 4'd5;
    localparam logic [3:0] ST_RID  = 4'd6;
    localparam logic [3:0] ST_AMD  = 4'd7;
    localparam logic [3:0] ST_INIT = 4'd8;
    localparam logic [3:0] ST_PROD = 4'd9;
    localparam logic [3:0] ST_CONS = 4'd10;
    localparam logic [3:0] ST_RUN  = 4'd11;

    // configuration registers
    logic [NODE_ID_W-1:0] r_node_id;
    logic [COUNT_W-1:0]   r_producer_count;
    logic [COUNT_W-1:0]   r_consumer_count;
    logic                 r_simple_protocol;
    logic [TICKS_W-1:0]   r_wait_ticks;

    // input register
    logic               r_in_valid;
    t_mode              r_in_mode;
    logic               r_in_acc;
    logic [TICKS_W-1:0] r_in_ticks;

    // login state
    logic [3:0]           r_step,      n_step;
    logic [NODE_ID_W-1:0] r_seed,      n_seed;
    logic [ALIAS_W-1:0]   r_alias,     n_alias;
    logic [CW-1:0]        r_cursor,    n_cursor;
    logic                 r_permitted, n_permitted;
    logic                 r_init,      n_init;

    // result register
    logic        r_out_valid;
    logic [39:0] r_out_data;
    t_kind       r_out_kind;

    // step results
    logic               n_frame_valid;
    t_kind              n_frame_kind;
    logic [ALIAS_W-1:0] n_slice;
    logic [EVENT_W-1:0] n_event;

    logic       w_s_take;
    logic       w_adv;
    t_alias_res w_gen;
    logic [SW-1:0] w_count;
    logic [SW-1:0] w_n;
    logic [SW-1:0] w_cursor_inc;

    assign o_cfg_ready   = 1'b1;
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_s_take      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

    // seed and alias for start / conflict
    cals_alias_gen u_alias_gen (
        .i_conflict (r_in_mode == MODE_CONFLICT),
        .i_seed     (r_seed),
        .i_node_id  (r_node_id),
        .o_res      (w_gen)
    );

    // saturated event count of the current phase
    always_comb begin
        w_count = (r_step == ST_PROD) ? SW'(r_producer_count) : SW'(r_consumer_count);
        w_n     = (w_count > MAX_EXT) ? MAX_EXT : w_count;
        w_cursor_inc = SW'(r_cursor) + SW'(1);
    end

    // one login step per item
    always_comb begin
        n_step        = r_step;
        n_seed        = r_seed;
        n_alias       = r_alias;
        n_cursor      = r_cursor;
        n_permitted   = r_permitted;
        n_init        = r_init;
        n_frame_valid = 1'b0;
        n_frame_kind  = KIND_CID7;
        n_slice       = '0;
        n_event       = '0;
        unique case (r_in_mode)
            MODE_START, MODE_CONFLICT: begin
                n_seed  = w_gen.seed;
                n_alias = w_gen.alias_val;
                n_step  = ST_CID7;
            end
            MODE_POLL: begin
                unique case (r_step)
                    ST_CID7: begin
                        n_frame_valid = 1'b1;
                        n_frame_kind  = KIND_CID7;
                        n_slice       = r_node_id[47:36];
                        if (r_in_acc) n_step = ST_CID6;
                    end
                    ST_CID6: begin
                        n_frame_valid = 1'b1;
                        n_frame_kind  = KIND_CID6;
                        n_slice       = r_node_id[35:24];
                        if (r_in_acc) n_step = ST_CID5;
                    end
                    ST_CID5: begin
                        n_frame_valid = 1'b1;
                        n_frame_kind  = KIND_CID5;
                        n_slice       = r_node_id[23:12];
                        if (r_in_acc) n_step = ST_CID4;
                    end
                    ST_CID4: begin
                        n_frame_valid = 1'b1;
                        n_frame_kind  = KIND_CID4;
                        n_slice       = r_node_id[11:0];
                        if (r_in_acc) n_step = ST_WAIT;
                    end
                    ST_WAIT: begin
                        if (r_in_ticks > r_wait_ticks) n_step = ST_RID;
                    end
                    ST_RID: begin
                        n_frame_valid = 1'b1;
                        n_frame_kind  = KIND_RID;
                        if (r_in_acc) n_step = ST_AMD;
                    end
                    ST_AMD: begin
                        n_frame_valid = 1'b1;
                        n_frame_kind  = KIND_AMD;
                        if (r_in_acc) begin
                            n_permitted = 1'b1;
                            n_step      = ST_INIT;
                        end
                    end
                    ST_INIT: begin
                        n_frame_valid = 1'b1;
                        n_frame_kind  = r_simple_protocol ? KIND_INIT_SIMPLE : KIND_INIT_FULL;
                        if (r_in_acc) begin
                            n_init   = 1'b1;
                            n_cursor = '0;
                            n_step   = ST_PROD;
                        end
                    end
                    ST_PROD, ST_CONS: begin
                        if (w_n == '0) begin
                            n_step = (r_step == ST_PROD) ? ST_CONS : ST_RUN;
                        end else begin
                            n_frame_valid = 1'b1;
                            n_frame_kind  = (r_step == ST_PROD) ? KIND_PRODUCER
                                                                : KIND_CONSUMER;
                            n_event       = EVENT_W'(r_cursor);
                            if (r_in_acc) begin
                                if (w_cursor_inc >= w_n) begin
                                    n_cursor = '0;
                                    n_step   = (r_step == ST_PROD) ? ST_CONS : ST_RUN;
                                end else begin
                                    n_cursor = CW'(w_cursor_inc);
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id         <= '0;
            r_producer_count  <= '0;
            r_consumer_count  <= '0;
            r_simple_protocol <= 1'b0;
            r_wait_ticks      <= WAIT_TICKS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_NODE_ID:         r_node_id         <= i_cfg_data;
                REG_PRODUCER_COUNT:  r_producer_count  <= i_cfg_data[COUNT_W-1:0];
                REG_CONSUMER_COUNT:  r_consumer_count  <= i_cfg_data[COUNT_W-1:0];
                REG_SIMPLE_PROTOCOL: r_simple_protocol <= i_cfg_data[0];
                REG_WAIT_TICKS:      r_wait_ticks      <= i_cfg_data[TICKS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_take) begin
            r_in_mode  <= s_axis_tuser;
            r_in_acc   <= s_axis_tdata[0];
            r_in_ticks <= s_axis_tdata[8:1];
        end
    end

    // login state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_IDLE;
            r_seed      <= '0;
            r_alias     <= '0;
            r_cursor    <= '0;
            r_permitted <= 1'b0;
            r_init      <= 1'b0;
        end else if (w_adv) begin
            r_step      <= n_step;
            r_seed      <= n_seed;
            r_alias     <= n_alias;
            r_cursor    <= n_cursor;
            r_permitted <= n_permitted;
            r_init      <= n_init;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_kind <= n_frame_kind;
            r_out_data <= {6'd0, (n_step == ST_RUN), n_init, n_permitted, n_event,
                           n_alias, n_slice, n_frame_valid};
        end
    end

`ifndef SYNTHESIS
    // run state is only reached after the init-complete frame went out
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_RUN) |-> (r_init && r_permitted))
        else $error("run state without init and permission");

    // a result without a frame carries the default kind (CID7) and a zero slice and event
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data[0]) |-> (r_out_kind == KIND_CID7 &&
                                             r_out_data[12:1] == '0 &&
                                             r_out_data[30:25] == '0))
        else $error("idle result carries frame fields");

    // permission is never withdrawn
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_permitted |=> r_permitted)
        else $error("permitted flag cleared");

    // a stalled input item is never dropped
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> r_in_valid)
        else $error("pending input item lost");
`endif

endmodule

`default_nettype wire
